@@ hdl/ices_pkg.sv @@
package ices_pkg;

    localparam int GROUP_W  = 3;
    localparam int SAMPLE_W = 8;
    localparam int PORT_W   = 7;
    localparam int BIT_W    = 3;
    localparam int MAP_W    = 64;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;
    localparam int CNT_W    = 4;

    typedef logic [GROUP_W-1:0]  t_group;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [PORT_W-1:0]   t_port;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_PIN_GROUPS = 2'd0,
        REG_PIN_GAP    = 2'd1,
        REG_DETENT_MAP = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_idx;

endpackage

@@ hdl/ices_in_if.sv @@
interface ices_in_if
    import ices_pkg::*;
();
    logic    valid;
    logic    ready;
    t_group  group;
    t_sample sample;

    modport source (output valid, output group, output sample, input ready);
    modport sink   (input valid, input group, input sample, output ready);
endinterface

@@ hdl/ices_out_if.sv @@
interface ices_out_if
    import ices_pkg::*;
();
    logic  valid;
    logic  ready;
    t_port port;
    logic  pressed;
    logic  final_res;

    modport source (output valid, output port, output pressed, output final_res, input ready);
    modport sink   (input valid, input port, input pressed, input final_res, output ready);
endinterface

@@ hdl/input_change_event_scanner.sv @@
// Change detector for groups of eight active-low inputs. Each request carries a group index
// and a freshly scanned byte; the byte is compared with the one stored for that group, which
// it then replaces, and every changed bit yields one event (port, pressed) in bit order 0 to 7,
// with final_res set on the last event of the request. Groups at or above pin_groups have
// pin_gap subtracted from the port (7-bit wraparound). A bit marked in detent_map is encoder
// channel A: it reports presses only, on port+1 when the next bit up reads high; channel B
// bits give no event. Requests for groups at or above GROUPS are taken and ignored. Events
// leave one per cycle while the receiver is ready, through an output register; a request
// holds the event buffer until its last event moves out, and the next request is taken in
// that cycle, so with the receiver ready requests of zero or one event never slow the input
// and flow at one per cycle. Stored bytes reset to zero. The user must write configuration
// over APB at byte addresses 0, 8 and 16 only while no events are pending; the block does not enforce it.
module input_change_event_scanner
    import ices_pkg::*;
#(
    parameter int GROUPS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ices_in_if.sink           i_in,
    ices_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // only eight groups are addressable by the group field
    localparam int DEPTH = (GROUPS < (1 << GROUP_W)) ? GROUPS : (1 << GROUP_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W = GROUP_W + 3;

    logic [CNT_W-1:0] r_pin_groups;
    logic [CNT_W-1:0] r_pin_gap;
    logic [MAP_W-1:0] r_detent_map;

    t_sample r_prev [DEPTH];

    logic [SAMPLE_W-1:0] r_ev_mask;
    logic [SAMPLE_W-1:0] r_ev_pressed;
    t_port               r_ev_port [SAMPLE_W];

    logic  r_out_valid;
    t_port r_out_port;
    logic  r_out_pressed;
    logic  r_out_final;

    // configuration port
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (reg_idx)
            REG_PIN_GROUPS: prdata = DATA_W'(r_pin_groups);
            REG_PIN_GAP:    prdata = DATA_W'(r_pin_gap);
            REG_DETENT_MAP: prdata = DATA_W'(r_detent_map);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_groups <= '0;
            r_pin_gap    <= '0;
            r_detent_map <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_PIN_GROUPS: r_pin_groups <= pwdata[CNT_W-1:0];
                REG_PIN_GAP:    r_pin_gap    <= pwdata[CNT_W-1:0];
                REG_DETENT_MAP: r_detent_map <= pwdata[MAP_W-1:0];
                default:        ;
            endcase
        end
    end

    // event extraction for an incoming request
    logic             grp_ok;
    logic [IDX_W-1:0] grp_idx;
    t_sample          prev_byte;
    t_sample          now;
    t_sample          diff;
    t_sample          marks;
    logic             gap_on;
    t_port            base_port;

    logic [SAMPLE_W-1:0] n_ev_mask;
    logic [SAMPLE_W-1:0] n_ev_pressed;
    t_port               n_ev_port [SAMPLE_W];

    assign grp_ok    = ({3'b000, i_in.group} < LIM_W'(GROUPS));
    assign grp_idx   = IDX_W'(i_in.group);
    assign now       = i_in.sample;
    assign prev_byte = grp_ok ? r_prev[grp_idx] : now;
    assign diff      = prev_byte ^ now;
    assign marks     = r_detent_map[{i_in.group, 3'b000} +: SAMPLE_W];
    assign gap_on    = ({1'b0, i_in.group} >= r_pin_groups);
    assign base_port = {1'b0, i_in.group, 3'b000} - (gap_on ? PORT_W'(r_pin_gap) : '0);

    always_comb begin
        for (int j = 0; j < SAMPLE_W; j++) begin
            logic drop;
            logic step;
            drop = 1'b0;
            step = 1'b0;
            if (marks[j]) begin
                if (now[j]) drop = 1'b1;
                if (j < SAMPLE_W - 1) step = now[(j + 1) % SAMPLE_W];
            end
            if (j != 0 && marks[(j + SAMPLE_W - 1) % SAMPLE_W]) drop = 1'b1;
            n_ev_mask[j]    = grp_ok && diff[j] && !drop;
            n_ev_pressed[j] = !now[j];
            n_ev_port[j]    = base_port + PORT_W'(j) + PORT_W'(step);
        end
    end

    // pick the lowest pending event
    logic [BIT_W-1:0]    pick;
    logic [SAMPLE_W-1:0] mask_rest;
    logic                buf_busy;
    logic                out_load;
    logic                in_take;

    always_comb begin
        pick = '0;
        for (int j = SAMPLE_W - 1; j >= 0; j--) begin
            if (r_ev_mask[j]) pick = BIT_W'(j);
        end
    end

    assign mask_rest = r_ev_mask & (r_ev_mask - 1'b1);
    assign buf_busy  = (r_ev_mask != '0);
    assign out_load  = buf_busy && (!r_out_valid || o_out.ready);
    assign in_take   = i_in.valid && i_in.ready;
    assign i_in.ready = !buf_busy || (out_load && (mask_rest == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_prev[k] <= '0;
        end else if (in_take && grp_ok) begin
            r_prev[grp_idx] <= now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_mask <= '0;
        end else if (in_take) begin
            r_ev_mask <= n_ev_mask;
        end else if (out_load) begin
            r_ev_mask <= mask_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ev_pressed <= n_ev_pressed;
            for (int j = 0; j < SAMPLE_W; j++) r_ev_port[j] <= n_ev_port[j];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_port    <= r_ev_port[pick];
            r_out_pressed <= r_ev_pressed[pick];
            r_out_final   <= (mask_rest == '0);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.port      = r_out_port;
    assign o_out.pressed   = r_out_pressed;
    assign o_out.final_res = r_out_final;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import ices_pkg::*;

    typedef struct {
        t_group  group;
        t_sample sample;
    } t_scan;

    typedef struct {
        t_port port;
        logic  pressed;
        logic  final_res;
    } t_event;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic    scan_valid = 1'b0;
    t_group  scan_group = '0;
    t_sample scan_sample = '0;
    logic    event_ready = 1'b0;
    logic    rx_hold = 1'b0;

    ices_in_if  in_bus ();
    ices_out_if out_bus ();

    assign in_bus.valid   = scan_valid;
    assign in_bus.group   = scan_group;
    assign in_bus.sample  = scan_sample;
    assign out_bus.ready  = event_ready;

    input_change_event_scanner #(
        .GROUPS(8)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // predictor state and its copy of the registers
    t_sample           last_sample [8];
    logic [3:0]        cfg_pin_groups = '0;
    logic [3:0]        cfg_pin_gap = '0;
    logic [MAP_W-1:0]  cfg_detent_map = '0;

    t_scan   scan_queue [$];
    t_event  expected_events [$];
    t_sample gen_last [8];
    int      scans_taken = 0;
    int      mismatches = 0;
    int      tx_idle_pct = 11;
    int      rx_idle_pct = 69;

    function automatic void scan_events(input t_group grp, input t_sample now);
        t_sample was;
        t_sample diff;
        t_sample marks;
        t_port   port;
        logic    pressed;
        t_event  evs [$];
        t_event  ev;
        was = last_sample[grp];
        last_sample[grp] = now;
        diff = was ^ now;
        marks = cfg_detent_map[grp*8 +: 8];
        for (int j = 0; j < 8; j++) begin
            if (diff[j]) begin
                port = {1'b0, grp, 3'(j)};
                pressed = ~now[j];
                if ({1'b0, grp} >= cfg_pin_groups)
                    port = port - t_port'(cfg_pin_gap);
                // channel a reports presses only; channel b bits are silent
                if (marks[j] && !pressed)
                    continue;
                if (marks[j] && j < 7 && now[(j+1) % 8])
                    port = port + 1'b1;
                if (j != 0 && marks[(j+7) % 8])
                    continue;
                ev.port = port;
                ev.pressed = pressed;
                ev.final_res = 1'b0;
                evs.push_back(ev);
            end
        end
        for (int k = 0; k < evs.size(); k++) begin
            ev = evs[k];
            ev.final_res = (k == evs.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_valid <= 1'b0;
        end else begin
            if (scan_valid && in_bus.ready) begin
                scan_events(scan_group, scan_sample);
                void'(scan_queue.pop_front());
                scans_taken++;
            end
            if (scan_valid && !in_bus.ready) begin
                // hold the request until it is taken
            end else if (scan_queue.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                scan_valid  <= 1'b1;
                scan_group  <= scan_queue[0].group;
                scan_sample <= scan_queue[0].sample;
            end else begin
                scan_valid <= 1'b0;
            end
        end
    end

    // event monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            event_ready <= 1'b0;
        end else begin
            if (out_bus.valid && event_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, got port %0d pressed %0b final %0b",
                             $time, out_bus.port, out_bus.pressed, out_bus.final_res);
                    mismatches++;
                end else begin
                    if (out_bus.port !== expected_events[0].port ||
                        out_bus.pressed !== expected_events[0].pressed ||
                        out_bus.final_res !== expected_events[0].final_res) begin
                        $display("%0t: event mismatch, expected port %0d pressed %0b final %0b, got port %0d pressed %0b final %0b",
                                 $time, expected_events[0].port, expected_events[0].pressed,
                                 expected_events[0].final_res, out_bus.port, out_bus.pressed,
                                 out_bus.final_res);
                        mismatches++;
                    end
                    void'(expected_events.pop_front());
                end
            end
            event_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // long receiver stall while the sender keeps offering requests
    initial begin
        wait (scans_taken >= 40);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic reg_write(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PIN_GROUPS: cfg_pin_groups = value[3:0];
            REG_PIN_GAP:    cfg_pin_gap = value[3:0];
            REG_DETENT_MAP: cfg_detent_map = value;
            default: ;
        endcase
    endtask

    task automatic queue_scan(input t_group grp, input t_sample smp);
        t_scan s;
        s.group = grp;
        s.sample = smp;
        scan_queue.push_back(s);
        gen_last[grp] = smp;
    endtask

    task automatic wait_drained();
        while (scan_queue.size() != 0 || scan_valid || expected_events.size() != 0)
            @(posedge i_clk);
        // a trailing request may cause no event but still be in flight
        repeat (12) @(posedge i_clk);
    endtask

    task automatic start_phase(input logic [3:0] groups, input logic [3:0] gap,
                               input logic [63:0] map, input int tx_pct, input int rx_pct);
        wait_drained();
        reg_write(REG_PIN_GROUPS, 64'(groups));
        reg_write(REG_PIN_GAP, 64'(gap));
        reg_write(REG_DETENT_MAP, map);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic queue_random(input int count);
        t_group  grp;
        t_sample smp;
        int      pick;
        for (int n = 0; n < count; n++) begin
            grp = t_group'($urandom_range(0, 7));
            smp = gen_last[grp];
            pick = $urandom_range(0, 99);
            // mostly single-bit steps, which is how encoder pairs move
            if (pick < 55)
                smp[$urandom_range(0, 7)] ^= 1'b1;
            else if (pick < 70)
                smp = smp ^ (8'h1 << $urandom_range(0, 7)) ^ (8'h1 << $urandom_range(0, 7));
            else if (pick < 88)
                smp = t_sample'($urandom_range(0, 255));
            queue_scan(grp, smp);
        end
    endtask

    initial begin
        for (int g = 0; g < 8; g++) begin
            last_sample[g] = '0;
            gen_last[g] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // group 0: channel a at bits 0, 1 (adjacent marks) and 7; group 1: two proper pairs
        start_phase(4'd0, 4'd3, 64'h0000_0000_0000_0583, 11, 69);
        queue_scan(3'd0, 8'hFF);
        queue_scan(3'd0, 8'h00);
        queue_scan(3'd0, 8'h00);
        queue_scan(3'd0, 8'hFE);
        queue_scan(3'd0, 8'hFF);
        queue_scan(3'd0, 8'hFE);
        queue_scan(3'd0, 8'h7F);
        queue_scan(3'd0, 8'hFF);
        queue_scan(3'd1, 8'hFF);
        queue_scan(3'd1, 8'hFE);
        queue_scan(3'd1, 8'hFA);
        queue_scan(3'd1, 8'hF0);
        queue_scan(3'd1, 8'h55);
        queue_scan(3'd1, 8'hAA);
        queue_scan(3'd2, 8'hFF);
        queue_scan(3'd2, 8'h00);
        queue_scan(3'd3, 8'h01);
        queue_scan(3'd3, 8'h80);
        queue_scan(3'd7, 8'hFF);
        queue_scan(3'd7, 8'h00);
        queue_scan(3'd7, 8'h00);

        start_phase(4'd3, 4'd5, {$urandom, $urandom} & 64'h5555_5555_5555_5555, 11, 69);
        queue_random(90);
        start_phase(4'd8, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 69, 11);
        queue_random(60);
        start_phase(4'd0, 4'd8, 64'h8080_8080_8080_8080 | {$urandom, $urandom}, 69, 11);
        queue_random(60);
        start_phase(4'd2, 4'd0, {$urandom, $urandom} & 64'h2A2A_5555_1515_AAAA, 0, 0);
        queue_random(80);
        start_phase(4'd8, 4'd0, 64'h0, 0, 0);
        queue_random(60);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("PASS input_change_event_scanner");
        end else begin
            $display("FAIL input_change_event_scanner");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL input_change_event_scanner");
        $finish;
    end

endmodule
